/* rtl/lxt_pkg.sv */
`timescale 1ns / 1ps
package lxt_pkg;

  localparam int IDX_W = 8;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } srch_t;

endpackage

/* rtl/lxt_cell.sv */
`timescale 1ns / 1ps
module lxt_cell #(
  parameter int W   = 64,
  parameter int IDX = 0,
  parameter int AW  = 6,
  parameter int CW  = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic [CW-1:0]        count,
  input  lxt_pkg::srch_t       st_i,
  input  logic [W-1:0]         key_i,
  output lxt_pkg::srch_t       st_o,
  output logic [W-1:0]         key_o
);

  localparam logic [AW-1:0] ADDR_C = AW'(IDX);
  localparam logic [CW-1:0] IDX_C  = CW'(IDX);

  logic [W-1:0] entry_r;
  logic         hit;

  assign hit = st_i.valid && !st_i.found && (IDX_C < count) && (entry_r == key_i);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == ADDR_C)) begin
      entry_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_o.valid <= 1'b0;
    end else begin
      st_o.valid <= st_i.valid;
    end
    st_o.found <= st_i.found | hit;
    st_o.idx   <= hit ? lxt_pkg::IDX_W'(IDX) : st_i.idx;
    key_o      <= key_i;
  end

endmodule

/* rtl/lexical_tokenizer_with_tables.sv */
`timescale 1ns / 1ps
// Each input beat is handled on its own; a constant or identifier end adds a lookup
// while the key walks the cell chain.
// The block takes one beat at a time: no new beat until the results of the last are taken.
// Reset (rst_n low, synchronous): lexer idle, line count 1, both tables empty.
module lexical_tokenizer_with_tables #(
  parameter int TABLE_DEPTH = 64,
  parameter int NAME_CHARS  = 8,
  parameter int CONST_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // token_kind, token_value, line_number, new_symbol
  output logic        out_tlast   // last_of_run
);

  localparam int NW = 8 * NAME_CHARS;
  localparam int CB = CONST_BITS;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CB-1:0] MAXV = {CB{1'b1}};

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_OUT0   = 2'd2;
  localparam logic [1:0] ST_OUT1   = 2'd3;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_NUM     = 4'd1;
  localparam logic [3:0] M_WORD    = 4'd2;
  localparam logic [3:0] M_SLASH   = 4'd3;
  localparam logic [3:0] M_LT      = 4'd4;
  localparam logic [3:0] M_GT      = 4'd5;
  localparam logic [3:0] M_EQ      = 4'd6;
  localparam logic [3:0] M_BANG    = 4'd7;
  localparam logic [3:0] M_COMMENT = 4'd8;

  localparam logic [4:0] K_IDENT   = 5'd7;
  localparam logic [4:0] K_CONST   = 5'd8;
  localparam logic [4:0] K_ADD     = 5'd9;
  localparam logic [4:0] K_SUB     = 5'd10;
  localparam logic [4:0] K_MUL     = 5'd11;
  localparam logic [4:0] K_DIV     = 5'd12;
  localparam logic [4:0] K_LT      = 5'd13;
  localparam logic [4:0] K_LE      = 5'd14;
  localparam logic [4:0] K_GT      = 5'd15;
  localparam logic [4:0] K_GE      = 5'd16;
  localparam logic [4:0] K_EQ      = 5'd17;
  localparam logic [4:0] K_ASSIGN  = 5'd18;
  localparam logic [4:0] K_NE      = 5'd19;
  localparam logic [4:0] K_OPEN    = 5'd20;
  localparam logic [4:0] K_CLOSE   = 5'd21;
  localparam logic [4:0] K_COMMA   = 5'd22;
  localparam logic [4:0] K_SEMI    = 5'd23;
  localparam logic [4:0] K_COMMENT = 5'd24;
  localparam logic [4:0] K_NEWLINE = 5'd25;
  localparam logic [4:0] K_END     = 5'd26;
  localparam logic [4:0] K_ILLEGAL = 5'd27;
  localparam logic [4:0] K_FULL    = 5'd28;

  localparam logic [7:0] C_0     = 8'h30;
  localparam logic [7:0] C_9     = 8'h39;
  localparam logic [7:0] C_SLASH = 8'h2f;
  localparam logic [7:0] C_LT    = 8'h3c;
  localparam logic [7:0] C_GT    = 8'h3e;
  localparam logic [7:0] C_EQ    = 8'h3d;
  localparam logic [7:0] C_BANG  = 8'h21;
  localparam logic [7:0] C_NL    = 8'h0a;

  localparam logic [63:0] KW_CODE [0:6] = '{
    64'h0000_0000_0074_6e69, 64'h0000_0000_0000_6669, 64'h0000_0000_6573_6c65,
    64'h0000_0065_6c69_6877, 64'h0000_0000_0072_6f66, 64'h0000_0000_6461_6572,
    64'h0000_0065_7469_7277
  };
  localparam logic [3:0] KW_LEN [0:6] = '{4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5};

  logic [1:0]    state_r, state_nxt;
  logic [3:0]    mode_r, mode_nxt;
  logic [63:0]   wbuf_r, wbuf_nxt;
  logic [3:0]    wlen_r, wlen_nxt;
  logic [CB-1:0] acc_r, acc_nxt;
  logic [15:0]   line_r, line_hold_r;
  logic [CW-1:0] ncount_r, vcount_r;
  logic          ssel_r;
  logic [4:0]    r0k_r, r1k_r;
  logic [7:0]    r0val_r, r1val_r;
  logic          r0new_r, r1v_r;

  logic [7:0] c;
  logic       acc_in, is_dig, is_let, is_blank;
  logic [3:0] s_mode;
  logic       s_ev, s_nl;
  logic [4:0] s_kind;
  logic [7:0] s_val;
  logic [CB-1:0] s_acc;
  logic [63:0]   s_wbuf;
  logic [3:0]    s_wlen;
  logic       kw_hit;
  logic [4:0] kw_kind;
  logic       r0v, r1v, srch, ssel, line_inc;
  logic [4:0] r0k, r1k;
  logic [7:0] r0val, r1val;
  logic [CB+3:0] acc_x10;

  lxt_pkg::srch_t nst [0:TABLE_DEPTH];
  lxt_pkg::srch_t vst [0:TABLE_DEPTH];
  logic [NW-1:0]  nkey [0:TABLE_DEPTH];
  logic [CB-1:0]  vkey [0:TABLE_DEPTH];
  logic           n_we, v_we, done;
  lxt_pkg::srch_t end_st;
  logic [CW-1:0]  sel_count;

  assign in_tready = (state_r == ST_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign is_dig    = (c >= C_0) && (c <= C_9);
  assign is_let    = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  assign is_blank  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d);
  assign acc_x10   = {1'b0, acc_r, 3'b000} + {3'b0, acc_r, 1'b0}
                     + {{CB{1'b0}}, c[3:0]};

  always_comb begin
    s_mode = M_IDLE;
    s_ev   = 1'b0;
    s_nl   = 1'b0;
    s_kind = K_ILLEGAL;
    s_val  = 8'd0;
    s_acc  = '0;
    s_wbuf = '0;
    s_wlen = 4'd0;
    if (is_blank) begin
      s_mode = M_IDLE;
    end else if (is_dig) begin
      s_mode = M_NUM;
      s_acc  = {{(CB-4){1'b0}}, c[3:0]};
    end else if (is_let) begin
      s_mode = M_WORD;
      s_wbuf = {56'd0, c};
      s_wlen = 4'd1;
    end else begin
      s_ev = 1'b1;
      case (c)
        8'h2b: s_kind = K_ADD;
        8'h2d: s_kind = K_SUB;
        8'h2a: s_kind = K_MUL;
        C_SLASH: begin s_ev = 1'b0; s_mode = M_SLASH; end
        C_LT:    begin s_ev = 1'b0; s_mode = M_LT; end
        C_GT:    begin s_ev = 1'b0; s_mode = M_GT; end
        C_EQ:    begin s_ev = 1'b0; s_mode = M_EQ; end
        C_BANG:  begin s_ev = 1'b0; s_mode = M_BANG; end
        8'h7b, 8'h5b, 8'h28: s_kind = K_OPEN;
        8'h7d, 8'h5d, 8'h29: s_kind = K_CLOSE;
        8'h2c: s_kind = K_COMMA;
        8'h3b: s_kind = K_SEMI;
        C_NL:  begin s_kind = K_NEWLINE; s_nl = 1'b1; end
        default: begin s_kind = K_ILLEGAL; s_val = c; end
      endcase
    end
  end

  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = 5'd0;
    for (int k = 0; k < 7; k++) begin
      if (!kw_hit && (wlen_r == KW_LEN[k]) && (wbuf_r == KW_CODE[k])) begin
        kw_hit  = 1'b1;
        kw_kind = 5'(k);
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    wbuf_nxt = wbuf_r;
    wlen_nxt = wlen_r;
    line_inc = 1'b0;
    r0v = 1'b0; r0k = K_END; r0val = 8'd0;
    r1v = 1'b0; r1k = K_END; r1val = 8'd0;
    srch = 1'b0;
    ssel = 1'b0;
    if (in_tlast) begin
      mode_nxt = M_IDLE;
      acc_nxt  = '0;
      wbuf_nxt = '0;
      wlen_nxt = 4'd0;
      r0v = 1'b1;
      r1k = K_END;
      case (mode_r)
        M_NUM:   begin srch = 1'b1; ssel = 1'b1; end
        M_WORD:  begin
          if (kw_hit) r0k = kw_kind;
          else srch = 1'b1;
        end
        M_SLASH: r0k = K_DIV;
        M_LT:    r0k = K_LT;
        M_GT:    r0k = K_GT;
        M_EQ:    r0k = K_ASSIGN;
        M_BANG:  r0k = K_ILLEGAL;
        default: r0k = K_END;
      endcase
      r1v = !((mode_r == M_IDLE) || (mode_r == M_COMMENT));
    end else begin
      case (mode_r)
        M_NUM: begin
          if (is_dig) begin
            acc_nxt = (acc_x10 > {4'b0, MAXV}) ? MAXV : acc_x10[CB-1:0];
          end else begin
            r0v = 1'b1; srch = 1'b1; ssel = 1'b1;
          end
        end
        M_WORD: begin
          if (is_dig || is_let) begin
            if (wlen_r < 4'd8) wbuf_nxt = wbuf_r | ({56'd0, c} << {wlen_r[2:0], 3'b000});
            if (wlen_r < 4'd15) wlen_nxt = wlen_r + 4'd1;
          end else begin
            r0v = 1'b1;
            if (kw_hit) r0k = kw_kind;
            else srch = 1'b1;
          end
        end
        M_SLASH: begin
          r0v = 1'b1;
          if (c == C_SLASH) r0k = K_COMMENT;
          else r0k = K_DIV;
        end
        M_LT: begin r0v = 1'b1; r0k = (c == C_EQ) ? K_LE : K_LT; end
        M_GT: begin r0v = 1'b1; r0k = (c == C_EQ) ? K_GE : K_GT; end
        M_EQ: begin r0v = 1'b1; r0k = (c == C_EQ) ? K_EQ : K_ASSIGN; end
        M_BANG: begin
          if (!is_blank) begin
            r0v = 1'b1;
            if (c == C_EQ) r0k = K_NE;
            else begin r0k = K_ILLEGAL; r0val = c; end
          end
        end
        M_COMMENT: begin
          if (c == C_NL) mode_nxt = M_IDLE;
        end
        default: begin
          r0v = s_ev; r0k = s_kind; r0val = s_val;
          mode_nxt = s_mode; acc_nxt = s_acc; wbuf_nxt = s_wbuf; wlen_nxt = s_wlen;
          line_inc = s_nl;
        end
      endcase
      if (r0v && (mode_r != M_IDLE)) begin
        if ((mode_r == M_SLASH) && (c == C_SLASH)) begin
          mode_nxt = M_COMMENT;
          line_inc = 1'b1;
        end else if (((mode_r == M_LT) || (mode_r == M_GT) || (mode_r == M_EQ) ||
                      (mode_r == M_BANG)) && (c == C_EQ)) begin
          mode_nxt = M_IDLE;
        end else begin
          r1v = s_ev; r1k = s_kind; r1val = s_val;
          mode_nxt = s_mode; acc_nxt = s_acc; wbuf_nxt = s_wbuf; wlen_nxt = s_wlen;
          line_inc = s_nl;
        end
      end
    end
  end

  assign nst[0]  = '{valid: acc_in && srch && !ssel, found: 1'b0, idx: '0};
  assign vst[0]  = '{valid: acc_in && srch && ssel, found: 1'b0, idx: '0};
  assign nkey[0] = wbuf_r[NW-1:0];
  assign vkey[0] = acc_r;

  assign end_st    = ssel_r ? vst[TABLE_DEPTH] : nst[TABLE_DEPTH];
  assign sel_count = ssel_r ? vcount_r : ncount_r;
  assign done      = (state_r == ST_SEARCH) && end_st.valid;
  assign n_we      = done && !end_st.found && !ssel_r && (ncount_r < DEPTH_C);
  assign v_we      = done && !end_st.found && ssel_r && (vcount_r < DEPTH_C);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cells
    lxt_cell #(.W(NW), .IDX(i), .AW(AW), .CW(CW)) u_ncell (
      .clk(clk), .rst_n(rst_n), .wr_en(n_we), .wr_addr(ncount_r[AW-1:0]),
      .wr_data(nkey[TABLE_DEPTH]), .count(ncount_r), .st_i(nst[i]), .key_i(nkey[i]),
      .st_o(nst[i+1]), .key_o(nkey[i+1])
    );
    lxt_cell #(.W(CB), .IDX(i), .AW(AW), .CW(CW)) u_vcell (
      .clk(clk), .rst_n(rst_n), .wr_en(v_we), .wr_addr(vcount_r[AW-1:0]),
      .wr_data(vkey[TABLE_DEPTH]), .count(vcount_r), .st_i(vst[i]), .key_i(vkey[i]),
      .st_o(vst[i+1]), .key_o(vkey[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (srch) state_nxt = ST_SEARCH;
          else if (r0v) state_nxt = ST_OUT0;
        end
      end
      ST_SEARCH: if (end_st.valid) state_nxt = ST_OUT0;
      ST_OUT0: begin
        if (out_tready) state_nxt = r1v_r ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= M_IDLE;
      wbuf_r   <= '0;
      wlen_r   <= 4'd0;
      acc_r    <= '0;
      line_r   <= 16'd1;
      ncount_r <= '0;
      vcount_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_in) begin
        mode_r <= mode_nxt;
        wbuf_r <= wbuf_nxt;
        wlen_r <= wlen_nxt;
        acc_r  <= acc_nxt;
        if (line_inc && (line_r != 16'hffff)) line_r <= line_r + 16'd1;
      end
      if (n_we) ncount_r <= ncount_r + 1'b1;
      if (v_we) vcount_r <= vcount_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      line_hold_r <= line_r;
      ssel_r      <= ssel;
      r0k_r       <= r0k;
      r0val_r     <= r0val;
      r0new_r     <= 1'b0;
      r1v_r       <= r1v;
      r1k_r       <= r1k;
      r1val_r     <= r1val;
    end else if (done) begin
      r0new_r <= 1'b0;
      if (end_st.found) begin
        r0k_r   <= ssel_r ? K_CONST : K_IDENT;
        r0val_r <= end_st.idx;
      end else if (sel_count < DEPTH_C) begin
        r0k_r   <= ssel_r ? K_CONST : K_IDENT;
        r0val_r <= 8'(sel_count);
        r0new_r <= !ssel_r;
      end else begin
        r0k_r   <= K_FULL;
        r0val_r <= 8'd0;
      end
    end
  end

  assign out_tvalid = (state_r == ST_OUT0) || (state_r == ST_OUT1);
  assign out_tlast  = (state_r == ST_OUT1) || !r1v_r;
  assign out_tdata  = (state_r == ST_OUT1) ?
                      {2'b00, 1'b0, line_hold_r, r1val_r, r1k_r} :
                      {2'b00, r0new_r, line_hold_r, r0val_r, r0k_r};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while a result is pending");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ncount_r <= DEPTH_C) && (vcount_r <= DEPTH_C)) else $error("table count overrun");
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0) else $error("line count wrapped");
  a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == ST_OUT0)) else $error("lookup result not presented");

endmodule
